[rtl/core/input_event_queue_filtered_pop_defines.svh]
// ----------------------------------------------------------------------------
// Input event queue: assertion macros
// Shared assertion forms for the event queue modules. Each macro samples on
// clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef INPUT_EVENT_QUEUE_FILTERED_POP_DEFINES_SVH
`define INPUT_EVENT_QUEUE_FILTERED_POP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IEQFP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IEQFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ieqfp_pkg.sv]
// ----------------------------------------------------------------------------
// Input event queue package
// Command codes, event class constants, the class filter and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ieqfp_pkg;

	localparam int unsigned ENTRY_W = 64;

	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_FILTER = 2'd2;

	localparam logic [15:0] KIND_SYNC  = 16'd0;
	localparam logic [15:0] KIND_KEY   = 16'd1;
	localparam logic [15:0] KIND_ABS   = 16'd3;
	localparam logic [15:0] CODE_SPLIT = 16'd256;

	typedef enum logic [1:0] {
		RD_HEAD  = 2'd0,
		RD_NEXT  = 2'd1,
		RD_NEXT2 = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_HOLD = 2'd0,
		RES_ZERO = 2'd1,
		RES_DROP = 2'd2,
		RES_LOAD = 2'd3
	} res_op_t;

	typedef struct packed {
		logic    latch_req;
		logic    push_write;
		logic    head_inc;
		logic    tail_dec;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    scan_load_head;
		logic    scan_advance;
		logic    shift_write;
		res_op_t res_op;
		logic    out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       empty;
		logic       match;
		logic       nx_tail;
		logic       nn_tail;
		logic       rsp_free;
	} dp_status_t;

	// True when the event belongs to a class that the filter enables.
	function automatic logic event_match(logic [15:0] kind, logic [15:0] code,
			logic ptr_on, logic key_on);
		logic is_key;
		logic is_ptr;
		logic is_sync;
		is_key  = (kind == KIND_KEY) && (code < CODE_SPLIT);
		is_ptr  = (kind == KIND_ABS) || ((kind == KIND_KEY) && (code >= CODE_SPLIT));
		is_sync = (kind == KIND_SYNC);
		return (is_key && key_on) || ((is_ptr || is_sync) && ptr_on);
	endfunction

endpackage

[rtl/core/ieqfp_datapath.sv]
// ----------------------------------------------------------------------------
// Input event queue datapath
// Event memory, head/tail/scan pointers, request capture, result staging and
// the output register.
// ----------------------------------------------------------------------------
`include "input_event_queue_filtered_pop_defines.svh"

module ieqfp_datapath #(
	parameter int unsigned DEPTH = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ieqfp_pkg::ctrl_cmd_t   ctl,
	output ieqfp_pkg::dp_status_t  sts,
	input  logic [1:0]             cmd,
	input  logic [15:0]            ev_kind,
	input  logic [15:0]            ev_code,
	input  logic [31:0]            ev_value,
	input  logic                   want_pointer,
	input  logic                   want_keyboard,
	input  logic                   rsp_ready,
	output logic                   rsp_valid,
	output logic                   got_event,
	output logic                   dropped,
	output logic [15:0]            out_kind,
	output logic [15:0]            out_code,
	output logic [31:0]            out_value
);
	import ieqfp_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	function automatic logic [PTR_W-1:0] wrap_next(logic [PTR_W-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] wrap_prev(logic [PTR_W-1:0] p);
		return (p == '0) ? LAST : p - 1'b1;
	endfunction

	logic [ENTRY_W-1:0] event_mem_q [DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;
	logic [ENTRY_W-1:0] wr_data;
	logic [PTR_W-1:0]   wr_addr;
	logic [PTR_W-1:0]   rd_addr;
	logic               wr_en;

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] scan_q;
	logic [PTR_W-1:0] scan_nx;
	logic [PTR_W-1:0] scan_nn;

	logic [1:0]  cmd_q;
	logic [15:0] kind_q;
	logic [15:0] code_q;
	logic [31:0] value_q;
	logic        want_ptr_q;
	logic        want_key_q;

	logic        res_got_q;
	logic        res_drop_q;
	logic [15:0] res_kind_q;
	logic [15:0] res_code_q;
	logic [31:0] res_value_q;

	logic        rsp_valid_q;
	logic        out_got_q;
	logic        out_drop_q;
	logic [15:0] out_kind_q;
	logic [15:0] out_code_q;
	logic [31:0] out_value_q;

	assign scan_nx = wrap_next(scan_q);
	assign scan_nn = wrap_next(scan_nx);

	// Memory port selection.
	assign wr_en   = ctl.push_write || ctl.shift_write;
	assign wr_addr = ctl.push_write ? tail_q : scan_q;
	assign wr_data = ctl.push_write ? {kind_q, code_q, value_q} : rd_data_q;

	always_comb begin
		case (ctl.rd_sel)
			RD_HEAD:  rd_addr = head_q;
			RD_NEXT:  rd_addr = scan_nx;
			RD_NEXT2: rd_addr = scan_nn;
			default:  rd_addr = head_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			event_mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= event_mem_q[rd_addr];
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (ctl.latch_req) begin
			cmd_q      <= cmd;
			kind_q     <= ev_kind;
			code_q     <= ev_code;
			value_q    <= ev_value;
			want_ptr_q <= want_pointer;
			want_key_q <= want_keyboard;
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.head_inc) begin
				head_q <= wrap_next(head_q);
			end
			if (ctl.push_write) begin
				tail_q <= wrap_next(tail_q);
			end else if (ctl.tail_dec) begin
				tail_q <= wrap_prev(tail_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_load_head) begin
			scan_q <= head_q;
		end else if (ctl.scan_advance) begin
			scan_q <= scan_nx;
		end
	end

	// Result staging.
	always_ff @(posedge clk) begin
		case (ctl.res_op)
			RES_HOLD: begin
			end
			RES_ZERO: begin
				res_got_q   <= 1'b0;
				res_drop_q  <= 1'b0;
				res_kind_q  <= '0;
				res_code_q  <= '0;
				res_value_q <= '0;
			end
			RES_DROP: begin
				res_got_q   <= 1'b0;
				res_drop_q  <= 1'b1;
				res_kind_q  <= '0;
				res_code_q  <= '0;
				res_value_q <= '0;
			end
			RES_LOAD: begin
				res_got_q   <= 1'b1;
				res_drop_q  <= 1'b0;
				res_kind_q  <= rd_data_q[63:48];
				res_code_q  <= rd_data_q[47:32];
				res_value_q <= rd_data_q[31:0];
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_got_q   <= res_got_q;
			out_drop_q  <= res_drop_q;
			out_kind_q  <= res_kind_q;
			out_code_q  <= res_code_q;
			out_value_q <= res_value_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign got_event = out_got_q;
	assign dropped   = out_drop_q;
	assign out_kind  = out_kind_q;
	assign out_code  = out_code_q;
	assign out_value = out_value_q;

	assign sts.cmd      = cmd_q;
	assign sts.full     = (wrap_next(tail_q) == head_q);
	assign sts.empty    = (head_q == tail_q);
	assign sts.match    = event_match(rd_data_q[63:48], rd_data_q[47:32],
		want_ptr_q, want_key_q);
	assign sts.nx_tail  = (scan_nx == tail_q);
	assign sts.nn_tail  = (scan_nn == tail_q);
	assign sts.rsp_free = !rsp_valid_q || rsp_ready;

	`IEQFP_ASSERT_IMPLY(a_push_not_full, ctl.push_write, !sts.full, "push into a full queue")
	`IEQFP_ASSERT_IMPLY(a_shift_not_tail, ctl.shift_write, wr_addr != tail_q, "shift write at the tail slot")
	`IEQFP_ASSERT_IMPLY(a_ptr_range, 1'b1, (head_q <= LAST) && (tail_q <= LAST), "pointer out of range")
	`IEQFP_ASSERT_IMPLY(a_shrink_nonempty, ctl.tail_dec, head_q != tail_q, "tail moved back on an empty queue")
	`IEQFP_ASSERT_NEXT(a_pop_moves_head, ctl.head_inc, head_q != $past(head_q), "head did not advance")

endmodule

[rtl/core/ieqfp_ctrl.sv]
// ----------------------------------------------------------------------------
// Input event queue controller
// Sequences push, pop and filtered pop (scan then close-up) over the datapath.
// ----------------------------------------------------------------------------
`include "input_event_queue_filtered_pop_defines.svh"

module ieqfp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  ieqfp_pkg::dp_status_t  sts,
	output ieqfp_pkg::ctrl_cmd_t   ctl
);
	import ieqfp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_DECODE   = 6'b000010,
		ST_POP_WAIT = 6'b000100,
		ST_SCAN     = 6'b001000,
		ST_SHIFT    = 6'b010000,
		ST_FINISH   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		ctl.rd_sel = RD_HEAD;
		ctl.res_op = RES_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctl.latch_req = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.cmd)
					CMD_PUSH: begin
						if (sts.full) begin
							ctl.res_op = RES_DROP;
						end else begin
							ctl.push_write = 1'b1;
							ctl.res_op = RES_ZERO;
						end
						state_d = ST_FINISH;
					end
					CMD_POP: begin
						if (sts.empty) begin
							ctl.res_op = RES_ZERO;
							state_d = ST_FINISH;
						end else begin
							ctl.rd_en = 1'b1;
							state_d = ST_POP_WAIT;
						end
					end
					CMD_FILTER: begin
						if (sts.empty) begin
							ctl.res_op = RES_ZERO;
							state_d = ST_FINISH;
						end else begin
							ctl.rd_en = 1'b1;
							ctl.scan_load_head = 1'b1;
							state_d = ST_SCAN;
						end
					end
					default: begin
						ctl.res_op = RES_ZERO;
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_POP_WAIT: begin
				ctl.res_op = RES_LOAD;
				ctl.head_inc = 1'b1;
				state_d = ST_FINISH;
			end
			ST_SCAN: begin
				if (sts.match) begin
					ctl.res_op = RES_LOAD;
					if (sts.nx_tail) begin
						ctl.tail_dec = 1'b1;
						state_d = ST_FINISH;
					end else begin
						ctl.rd_en = 1'b1;
						ctl.rd_sel = RD_NEXT;
						state_d = ST_SHIFT;
					end
				end else if (sts.nx_tail) begin
					ctl.res_op = RES_ZERO;
					state_d = ST_FINISH;
				end else begin
					ctl.rd_en = 1'b1;
					ctl.rd_sel = RD_NEXT;
					ctl.scan_advance = 1'b1;
				end
			end
			ST_SHIFT: begin
				ctl.shift_write = 1'b1;
				ctl.scan_advance = 1'b1;
				if (sts.nn_tail) begin
					ctl.tail_dec = 1'b1;
					state_d = ST_FINISH;
				end else begin
					ctl.rd_en = 1'b1;
					ctl.rd_sel = RD_NEXT2;
				end
			end
			ST_FINISH: begin
				if (sts.rsp_free) begin
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`IEQFP_ASSERT_NEXT(a_accept_decodes, req_valid && req_ready, state_q == ST_DECODE, "accepted transfer not decoded")
	`IEQFP_ASSERT_IMPLY(a_load_when_free, ctl.out_load, sts.rsp_free, "output overwritten before transfer")
	`IEQFP_ASSERT_IMPLY(a_single_port_use, ctl.push_write, !ctl.shift_write, "two writes in one cycle")

endmodule

[rtl/core/input_event_queue_filtered_pop.sv]
// ----------------------------------------------------------------------------
// Input event queue with filtered pop
// Circular queue of input events with push, pop-oldest and class-filtered pop.
// ----------------------------------------------------------------------------
// The block holds up to DEPTH-1 events of 64 bits (kind, code, value) in a
// single-port-write, single-port-read memory with registered read data, and
// processes one request transfer at a time. A push writes the tail slot and
// a plain pop stages the head entry from the registered read data, each then
// waiting until the output register is free. A filtered pop reads the memory
// one entry per cycle from the oldest event until it finds one whose class is
// enabled (keyboard: kind 1 with code below 256; pointer: kind 3 or kind 1
// with code 256 or more; sync: kind 0, enabled with pointer), then closes the
// gap by copying each later entry one slot down, also one entry per cycle. If
// no entry up to the newest matches, it returns no event. A push into a full
// queue is discarded and reported with dropped. The result sits in an output
// register, so a new request is accepted while the previous result still
// waits for its transfer. The event memory is not cleared at reset; only
// occupied slots are ever read.
module input_event_queue_filtered_pop #(
	parameter int unsigned DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] ev_kind,
	input  logic [15:0] ev_code,
	input  logic [31:0] ev_value,
	input  logic        want_pointer,
	input  logic        want_keyboard,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        got_event,
	output logic        dropped,
	output logic [15:0] out_kind,
	output logic [15:0] out_code,
	output logic [31:0] out_value
);
	import ieqfp_pkg::*;

	// Command and status between the sequencer and the datapath.
	ctrl_cmd_t  ctl;
	dp_status_t sts;

	ieqfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	ieqfp_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.ev_kind       (ev_kind),
		.ev_code       (ev_code),
		.ev_value      (ev_value),
		.want_pointer  (want_pointer),
		.want_keyboard (want_keyboard),
		.rsp_ready     (rsp_ready),
		.rsp_valid     (rsp_valid),
		.got_event     (got_event),
		.dropped       (dropped),
		.out_kind      (out_kind),
		.out_code      (out_code),
		.out_value     (out_value)
	);

endmodule
